FILE: hdl/blsi_pkg.sv
// Shared types, constants and a helper function of the blocked lattice site indexer.
`timescale 1ns / 1ps

package blsi_pkg;

  localparam int MaxExtentDef = 64;

  localparam int CoordW   = 6;
  localparam int ExtW     = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgW     = 7;
  localparam int IdxW     = 24;
  localparam int SpW      = 18;
  localparam int NumIdx   = 9;
  localparam int InDataW  = 4 * CoordW;
  localparam int OutDataW = ((NumIdx * IdxW + SpW + 7) / 8) * 8;

  localparam logic [2:0] BLK_4 = 3'd4;
  localparam logic [2:0] BLK_3 = 3'd3;
  localparam logic [2:0] BLK_2 = 3'd2;
  localparam logic [2:0] BLK_1 = 3'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_T_EXTENT   = 3'd0,
    CFG_X_EXTENT   = 3'd1,
    CFG_Y_EXTENT   = 3'd2,
    CFG_Z_EXTENT   = 3'd3,
    CFG_INTERLEAVE = 3'd4
  } blsi_cfg_idx_t;

  typedef struct packed {
    logic [ExtW-1:0] te;
    logic [ExtW-1:0] xe;
    logic [ExtW-1:0] ye;
    logic [ExtW-1:0] ze;
    logic [2:0]      bx;
    logic [2:0]      by;
    logic [2:0]      bz;
    logic [6:0]      nz;
    logic [4:0]      bzy;
    logic [13:0]     nzy;
    logic [13:0]     yz;
    logic [6:0]      vol;
    logic [12:0]     tv;
    logic            il;
  } blsi_geom_t;

  // Floor of v / 3 for v below 128, by multiplication with 43/128.
  function automatic logic [6:0] div3(input logic [6:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd43;
    return {1'b0, p[12:7]};
  endfunction

endpackage

FILE: hdl/blsi_geom.sv
// Configuration registers and the lattice geometry derived from them.
`timescale 1ns / 1ps

module blsi_geom #(
  parameter int MAX_EXTENT = blsi_pkg::MaxExtentDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [blsi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [blsi_pkg::CfgW-1:0]    cfg_wdata,
  output blsi_pkg::blsi_geom_t         geom
);
  import blsi_pkg::*;

  localparam logic [8:0] MaxExt = 9'(MAX_EXTENT);

  logic [ExtW-1:0] t_ext_r, x_ext_r, y_ext_r, z_ext_r;
  logic            il_r;

  logic [ExtW-1:0] te_a_r, xe_a_r, ye_a_r, ze_a_r;
  logic [2:0]      bx_a_r, by_a_r, bz_a_r;
  logic [6:0]      ny_a_r, nz_a_r;
  logic            il_a_r;

  logic [ExtW-1:0] te_a_nxt, xe_a_nxt, ye_a_nxt, ze_a_nxt;
  logic [2:0]      bx_a_nxt, by_a_nxt, bz_a_nxt;

  logic [4:0]      bzy_b_r;
  logic [13:0]     nzy_b_r, yz_b_r;
  logic [2:0]      bx_b_r;
  logic [ExtW-1:0] te_b_r;

  logic [6:0]      vol_c_r;
  logic [ExtW-1:0] te_c_r;

  logic [12:0]     tv_d_r;

  function automatic logic [6:0] clamp_ext(input logic [6:0] raw);
    logic [6:0] e;
    if (raw == 7'd0) begin
      e = 7'd1;
    end else if ({2'b00, raw} > MaxExt) begin
      e = MaxExt[6:0];
    end else begin
      e = raw;
    end
    return e;
  endfunction

  function automatic logic [2:0] blk_size(input logic [6:0] e);
    logic [2:0] b;
    if (e[1:0] == 2'b00) begin
      b = BLK_4;
    end else if ((div3(e) * 7'd3) == e) begin
      b = BLK_3;
    end else if (!e[0]) begin
      b = BLK_2;
    end else begin
      b = BLK_1;
    end
    return b;
  endfunction

  function automatic logic [6:0] blk_count(input logic [6:0] e, input logic [2:0] b);
    logic [6:0] n;
    case (b)
      BLK_4:   n = {2'b00, e[6:2]};
      BLK_3:   n = div3(e);
      BLK_2:   n = {1'b0, e[6:1]};
      default: n = e;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_ext_r <= 7'd8;
      x_ext_r <= 7'd8;
      y_ext_r <= 7'd8;
      z_ext_r <= 7'd8;
      il_r    <= 1'b1;
    end else if (cfg_we) begin
      case (blsi_cfg_idx_t'(cfg_index))
        CFG_T_EXTENT:   t_ext_r <= cfg_wdata[ExtW-1:0];
        CFG_X_EXTENT:   x_ext_r <= cfg_wdata[ExtW-1:0];
        CFG_Y_EXTENT:   y_ext_r <= cfg_wdata[ExtW-1:0];
        CFG_Z_EXTENT:   z_ext_r <= cfg_wdata[ExtW-1:0];
        CFG_INTERLEAVE: il_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    te_a_nxt = clamp_ext(t_ext_r);
    xe_a_nxt = clamp_ext(x_ext_r);
    ye_a_nxt = clamp_ext(y_ext_r);
    ze_a_nxt = clamp_ext(z_ext_r);
    bx_a_nxt = blk_size(xe_a_nxt);
    by_a_nxt = blk_size(ye_a_nxt);
    bz_a_nxt = blk_size(ze_a_nxt);
  end

  always_ff @(posedge clk) begin
    te_a_r <= te_a_nxt;
    xe_a_r <= xe_a_nxt;
    ye_a_r <= ye_a_nxt;
    ze_a_r <= ze_a_nxt;
    bx_a_r <= bx_a_nxt;
    by_a_r <= by_a_nxt;
    bz_a_r <= bz_a_nxt;
    ny_a_r <= blk_count(ye_a_nxt, by_a_nxt);
    nz_a_r <= blk_count(ze_a_nxt, bz_a_nxt);
    il_a_r <= il_r;

    bzy_b_r <= 5'(bz_a_r) * 5'(by_a_r);
    nzy_b_r <= 14'(nz_a_r) * 14'(ny_a_r);
    yz_b_r  <= 14'(ye_a_r) * 14'(ze_a_r);
    bx_b_r  <= bx_a_r;
    te_b_r  <= te_a_r;

    vol_c_r <= 7'(bzy_b_r) * 7'(bx_b_r);
    te_c_r  <= te_b_r;

    tv_d_r  <= 13'(te_c_r) * 13'(vol_c_r);
  end

  always_comb begin
    geom.te  = te_a_r;
    geom.xe  = xe_a_r;
    geom.ye  = ye_a_r;
    geom.ze  = ze_a_r;
    geom.bx  = bx_a_r;
    geom.by  = by_a_r;
    geom.bz  = bz_a_r;
    geom.nz  = nz_a_r;
    geom.bzy = bzy_b_r;
    geom.nzy = nzy_b_r;
    geom.yz  = yz_b_r;
    geom.vol = vol_c_r;
    geom.tv  = tv_d_r;
    geom.il  = il_a_r;
  end

endmodule

FILE: hdl/blocked_lattice_site_index.sv
// Top level of the blocked lattice site indexer: eight-stage index pipeline.
// An accepted input beat passes through the eight registered stages in turn to its result beat.
// Throughput is one beat per cycle unless the output stalls; every stage carries a valid bit.
// A stalled output fills empty stages first, so input stays ready until all eight are full.
// Synchronous active-low reset empties the pipeline and sets the extents to 8, interleave on.
`timescale 1ns / 1ps

module blocked_lattice_site_index #(
  parameter int MAX_EXTENT = blsi_pkg::MaxExtentDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0 up: coord_t, coord_x, coord_y, coord_z.
  input  logic [blsi_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0 up: site_index, up_t_index, down_t_index, up_x_index,
  // down_x_index, up_y_index, down_y_index, up_z_index, down_z_index,
  // spatial_index, zero fill.
  output logic [blsi_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [blsi_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [blsi_pkg::CfgW-1:0]     cfg_wdata
);
  import blsi_pkg::*;

  localparam int NS = 8;

  localparam int TSel [NumIdx] = '{0, 1, 2, 0, 0, 0, 0, 0, 0};
  localparam int SSel [NumIdx] = '{0, 0, 0, 1, 2, 3, 4, 5, 6};
  localparam int XSel [7] = '{0, 1, 2, 0, 0, 0, 0};
  localparam int YSel [7] = '{0, 0, 0, 1, 2, 0, 0};
  localparam int ZSel [7] = '{0, 0, 0, 0, 0, 1, 2};

  typedef struct packed {
    logic [6:0] q;
    logic [1:0] o;
  } qo_t;

  blsi_geom_t geom;

  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;

  logic [ExtW-1:0] ext [4];
  logic [2:0]      bsz [3];

  logic [CoordW-1:0] c1_r [4], c1_nxt [4];
  logic [CoordW-1:0] r2_r [4], r2_nxt [4];
  logic [CoordW-1:0] c3_r [4], c3_nxt [4];

  logic [6:0]        t4_r [3], t4_nxt [3];
  logic [6:0]        q4_r [3][3], q4_nxt [3][3];
  logic [1:0]        o4_r [3][3], o4_nxt [3][3];
  logic [CoordW-1:0] cs4_r [3], cs4_nxt [3];

  logic [13:0] tb5_r [3], tb5_nxt [3];
  logic        tl5_r [3], tl5_nxt [3];
  logic [1:0]  oz5_r [3], oz5_nxt [3];
  logic [3:0]  oy5_r [3], oy5_nxt [3];
  logic [5:0]  ox5_r [3], ox5_nxt [3];
  logic [6:0]  bz5_r [3], bz5_nxt [3];
  logic [13:0] by5_r [3], by5_nxt [3];
  logic [20:0] bx5_r [3], bx5_nxt [3];
  logic [20:0] spx5_r, spx5_nxt;
  logic [13:0] spy5_r, spy5_nxt;
  logic [CoordW-1:0] spz5_r, spz5_nxt;

  logic [5:0]     off6_r [7], off6_nxt [7];
  logic [21:0]    blk6_r [7], blk6_nxt [7];
  logic [13:0]    tb6_r [3];
  logic           tl6_r [3];
  logic [SpW-1:0] sp6_r, sp6_nxt;

  logic [14:0]     inb7_r [NumIdx], inb7_nxt [NumIdx];
  logic [IdxW-1:0] prod7_r [NumIdx], prod7_nxt [NumIdx];
  logic [SpW-1:0]  sp7_r;

  logic [IdxW-1:0] idx8_r [NumIdx], idx8_nxt [NumIdx];
  logic [SpW-1:0]  sp8_r;

  function automatic qo_t split(input logic [6:0] c, input logic [2:0] b);
    qo_t        s;
    logic [6:0] q3;
    q3 = div3(c);
    case (b)
      BLK_4: begin
        s.q = {2'b00, c[6:2]};
        s.o = c[1:0];
      end
      BLK_3: begin
        s.q = q3;
        s.o = 2'(c - 7'(q3 * 7'd3));
      end
      BLK_2: begin
        s.q = {1'b0, c[6:1]};
        s.o = {1'b0, c[0]};
      end
      default: begin
        s.q = c;
        s.o = 2'b00;
      end
    endcase
    return s;
  endfunction

  blsi_geom #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  always_comb begin
    ext[0] = geom.te;
    ext[1] = geom.xe;
    ext[2] = geom.ye;
    ext[3] = geom.ze;
    bsz[0] = geom.bx;
    bsz[1] = geom.by;
    bsz[2] = geom.bz;
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    rdy[NS+1] = out_tready;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready  = rdy[1] & rst_n;
  assign out_tvalid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      c1_nxt[a] = in_tdata[a*CoordW +: CoordW];
    end
  end

  // Coordinate modulo extent, restoring steps for quotient bits 5 to 3.
  always_comb begin
    logic [CoordW-1:0] r;
    logic [12:0]       d;
    for (int a = 0; a < 4; a++) begin
      r = c1_r[a];
      for (int k = 5; k >= 3; k--) begin
        d = 13'(ext[a]) << k;
        if ({7'd0, r} >= d) begin
          r = 6'({7'd0, r} - d);
        end
      end
      r2_nxt[a] = r;
    end
  end

  // Quotient bits 2 to 0.
  always_comb begin
    logic [CoordW-1:0] r;
    logic [12:0]       d;
    for (int a = 0; a < 4; a++) begin
      r = r2_r[a];
      for (int k = 2; k >= 0; k--) begin
        d = 13'(ext[a]) << k;
        if ({7'd0, r} >= d) begin
          r = 6'({7'd0, r} - d);
        end
      end
      c3_nxt[a] = r;
    end
  end

  // Wrapped neighbor coordinates; x, y and z ones split into block number and in-block offset.
  always_comb begin
    logic [6:0] c;
    logic [6:0] up;
    logic [6:0] var3 [3];
    qo_t        s;
    for (int a = 0; a < 4; a++) begin
      c  = 7'(c3_r[a]);
      up = c + 7'd1;
      var3[0] = c;
      var3[1] = (up >= ext[a]) ? 7'd0 : up;
      var3[2] = (c == 7'd0) ? (ext[a] - 7'd1) : (c - 7'd1);
      if (a == 0) begin
        for (int w = 0; w < 3; w++) begin
          t4_nxt[w] = var3[w];
        end
      end else begin
        for (int w = 0; w < 3; w++) begin
          s = split(var3[w], bsz[a-1]);
          q4_nxt[a-1][w] = s.q;
          o4_nxt[a-1][w] = s.o;
        end
        cs4_nxt[a-1] = c3_r[a];
      end
    end
  end

  always_comb begin
    logic [6:0] ts;
    for (int w = 0; w < 3; w++) begin
      ts = geom.il ? {t4_r[w][6:1], 1'b0} : t4_r[w];
      tb5_nxt[w] = 14'(ts) * 14'(geom.vol);
      tl5_nxt[w] = geom.il & t4_r[w][0];
      oz5_nxt[w] = o4_r[2][w];
      oy5_nxt[w] = 4'(o4_r[1][w]) * 4'(geom.bz);
      ox5_nxt[w] = 6'(o4_r[0][w]) * 6'(geom.bzy);
      bz5_nxt[w] = q4_r[2][w];
      by5_nxt[w] = 14'(q4_r[1][w]) * 14'(geom.nz);
      bx5_nxt[w] = 21'(q4_r[0][w]) * 21'(geom.nzy);
    end
    spx5_nxt = 21'(cs4_r[0]) * 21'(geom.yz);
    spy5_nxt = 14'(cs4_r[1]) * 14'(geom.ze);
    spz5_nxt = cs4_r[2];
  end

  always_comb begin
    for (int sv = 0; sv < 7; sv++) begin
      off6_nxt[sv] = 6'(oz5_r[ZSel[sv]]) + 6'(oy5_r[YSel[sv]]) + ox5_r[XSel[sv]];
      blk6_nxt[sv] = 22'(bz5_r[ZSel[sv]]) + 22'(by5_r[YSel[sv]]) + 22'(bx5_r[XSel[sv]]);
    end
    sp6_nxt = 18'(spx5_r) + 18'(spy5_r) + 18'(spz5_r);
  end

  always_comb begin
    logic [14:0] offs;
    for (int k = 0; k < NumIdx; k++) begin
      offs = geom.il ? 15'({off6_r[SSel[k]], 1'b0}) : 15'(off6_r[SSel[k]]);
      inb7_nxt[k]  = 15'(tb6_r[TSel[k]]) + offs + 15'(tl6_r[TSel[k]]);
      prod7_nxt[k] = 24'(blk6_r[SSel[k]]) * 24'(geom.tv);
    end
  end

  always_comb begin
    for (int k = 0; k < NumIdx; k++) begin
      idx8_nxt[k] = 24'(inb7_r[k]) + prod7_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c1_r <= c1_nxt;
    end
    if (rdy[2]) begin
      r2_r <= r2_nxt;
    end
    if (rdy[3]) begin
      c3_r <= c3_nxt;
    end
    if (rdy[4]) begin
      t4_r  <= t4_nxt;
      q4_r  <= q4_nxt;
      o4_r  <= o4_nxt;
      cs4_r <= cs4_nxt;
    end
    if (rdy[5]) begin
      tb5_r  <= tb5_nxt;
      tl5_r  <= tl5_nxt;
      oz5_r  <= oz5_nxt;
      oy5_r  <= oy5_nxt;
      ox5_r  <= ox5_nxt;
      bz5_r  <= bz5_nxt;
      by5_r  <= by5_nxt;
      bx5_r  <= bx5_nxt;
      spx5_r <= spx5_nxt;
      spy5_r <= spy5_nxt;
      spz5_r <= spz5_nxt;
    end
    if (rdy[6]) begin
      off6_r <= off6_nxt;
      blk6_r <= blk6_nxt;
      tb6_r  <= tb5_r;
      tl6_r  <= tl5_r;
      sp6_r  <= sp6_nxt;
    end
    if (rdy[7]) begin
      inb7_r  <= inb7_nxt;
      prod7_r <= prod7_nxt;
      sp7_r   <= sp6_r;
    end
    if (rdy[8]) begin
      idx8_r <= idx8_nxt;
      sp8_r  <= sp7_r;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NumIdx; k++) begin
      out_tdata[k*IdxW +: IdxW] = idx8_r[k];
    end
    out_tdata[NumIdx*IdxW +: SpW] = sp8_r;
  end

endmodule

FILE: hdl/blsi_checker.sv
// Port-level checker for the blocked lattice site indexer and its bind.
`timescale 1ns / 1ps

module blsi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [blsi_pkg::OutDataW-1:0] out_tdata
);
  import blsi_pkg::*;

  localparam int UsedW = NumIdx * IdxW + SpW;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  // A result beat that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // Input is refused only when the last stage is full and the output is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused while the output is free");

  // The fill above the last field is always zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutDataW-1:UsedW] == '0)
    else $error("fill bits of result beat not zero");

endmodule

bind blocked_lattice_site_index blsi_checker u_blsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/tb_blocked_lattice_site_index.sv
// Self-checking testbench of the blocked lattice site indexer with its own index predictor.
`timescale 1ns / 1ps

module tb_blocked_lattice_site_index;
  import blsi_pkg::*;

  localparam int MaxExt = MaxExtentDef;
  localparam int RandPhases = 10;
  localparam int SitesPerPhase = 75;
  localparam int IdlePct = 18;
  localparam int DrainCycles = 12;
  localparam int ExtTop = (1 << ExtW) - 1;
  localparam int CoordTop = (1 << CoordW) - 1;

  typedef struct packed {
    logic [SpW-1:0]              spatial;
    logic [NumIdx-1:0][IdxW-1:0] idx;
  } site_indices_t;

  typedef struct {
    int unsigned te, ex, ey, ez;
    int unsigned bx, by, bz;
    int unsigned ny, nz;
    bit          il;
  } lattice_geom_t;

  typedef struct {
    logic [ExtW-1:0]   te, xe, ye, ze;
    logic              il;
    logic [CoordW-1:0] ct, cx, cy, cz;
    bit                typed;
    site_indices_t     want;
  } site_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  logic [ExtW-1:0] t_ext = 7'd8;
  logic [ExtW-1:0] x_ext = 7'd8;
  logic [ExtW-1:0] y_ext = 7'd8;
  logic [ExtW-1:0] z_ext = 7'd8;
  logic            il_mode = 1'b1;

  bit              calm = 1'b0;
  int              errors = 0;
  site_indices_t   expected_sites[$];
  string           idx_names[NumIdx] = '{"site_index", "up_t_index", "down_t_index",
                                         "up_x_index", "down_x_index", "up_y_index",
                                         "down_y_index", "up_z_index", "down_z_index"};

  blocked_lattice_site_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_ext(logic [ExtW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxExt) return MaxExt;
    return raw;
  endfunction

  function automatic int unsigned axis_block(int unsigned e);
    if (e % 4 == 0) return BLK_4;
    if (e % 3 == 0) return BLK_3;
    if (e % 2 == 0) return BLK_2;
    return BLK_1;
  endfunction

  function automatic lattice_geom_t current_geom();
    lattice_geom_t g;
    g.te = clamp_ext(t_ext);
    g.ex = clamp_ext(x_ext);
    g.ey = clamp_ext(y_ext);
    g.ez = clamp_ext(z_ext);
    g.bx = axis_block(g.ex);
    g.by = axis_block(g.ey);
    g.bz = axis_block(g.ez);
    g.ny = g.ey / g.by;
    g.nz = g.ez / g.bz;
    g.il = il_mode;
    return g;
  endfunction

  function automatic logic [IdxW-1:0] blocked_index(lattice_geom_t g,
                                                    int unsigned t, x, y, z);
    longint unsigned vol, off, blk, inb;
    vol = g.bx * g.by * g.bz;
    off = z % g.bz + (y % g.by) * g.bz + (x % g.bx) * g.bz * g.by;
    blk = z / g.bz + (y / g.by) * g.nz + (x / g.bx) * g.nz * g.ny;
    if (g.il) inb = (t - t % 2) * vol + 2 * off + t % 2;
    else inb = t * vol + off;
    return IdxW'(inb + blk * g.te * vol);
  endfunction

  function automatic int unsigned step_up(int unsigned c, int unsigned e);
    return (c + 1 >= e) ? 0 : c + 1;
  endfunction

  function automatic int unsigned step_dn(int unsigned c, int unsigned e);
    return (c == 0) ? e - 1 : c - 1;
  endfunction

  function automatic site_indices_t predict_site_indices(logic [CoordW-1:0] ct, cx, cy, cz);
    lattice_geom_t g;
    site_indices_t r;
    int unsigned t, x, y, z;
    g = current_geom();
    t = ct % g.te;
    x = cx % g.ex;
    y = cy % g.ey;
    z = cz % g.ez;
    r.idx[0] = blocked_index(g, t, x, y, z);
    r.idx[1] = blocked_index(g, step_up(t, g.te), x, y, z);
    r.idx[2] = blocked_index(g, step_dn(t, g.te), x, y, z);
    r.idx[3] = blocked_index(g, t, step_up(x, g.ex), y, z);
    r.idx[4] = blocked_index(g, t, step_dn(x, g.ex), y, z);
    r.idx[5] = blocked_index(g, t, x, step_up(y, g.ey), z);
    r.idx[6] = blocked_index(g, t, x, step_dn(y, g.ey), z);
    r.idx[7] = blocked_index(g, t, x, y, step_up(z, g.ez));
    r.idx[8] = blocked_index(g, t, x, y, step_dn(z, g.ez));
    r.spatial = SpW'(x * g.ey * g.ez + y * g.ez + z);
    return r;
  endfunction

  function automatic site_row_t lattice_row(logic [ExtW-1:0] te, xe, ye, ze, logic il,
                                            logic [CoordW-1:0] ct, cx, cy, cz);
    site_row_t r;
    r.te = te;
    r.xe = xe;
    r.ye = ye;
    r.ze = ze;
    r.il = il;
    r.ct = ct;
    r.cx = cx;
    r.cy = cy;
    r.cz = cz;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic logic [ExtW-1:0] rand_extent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ExtW'(MaxExt);
      2: return ExtW'($urandom_range(MaxExt + 1, ExtTop));
      3, 4: return ExtW'($urandom_range(1, MaxExt));
      default: return ExtW'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CoordW-1:0] pick_coord(int unsigned e);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CoordW'(e - 1);
      2, 3: return CoordW'($urandom_range(0, CoordTop));
      default: return CoordW'($urandom_range(0, e - 1));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic configure_lattice(input logic [ExtW-1:0] te, xe, ye, ze, input logic il);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_sites.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    write_reg(CFG_T_EXTENT, te);
    write_reg(CFG_X_EXTENT, xe);
    write_reg(CFG_Y_EXTENT, ye);
    write_reg(CFG_Z_EXTENT, ze);
    write_reg(CFG_INTERLEAVE, {(CfgW-1)'($urandom), il});
    if ($urandom_range(0, 1))
      write_reg(CfgIdxW'($urandom_range(int'(CFG_INTERLEAVE) + 1, (1 << CfgIdxW) - 1)),
                CfgW'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    t_ext   = te;
    x_ext   = xe;
    y_ext   = ye;
    z_ext   = ze;
    il_mode = il;
  endtask

  task automatic send_site(input logic [CoordW-1:0] ct, cx, cy, cz, input bit typed,
                           input site_indices_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cz, cy, cx, ct};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_sites.push_back(typed ? want : predict_site_indices(ct, cx, cy, cz));
  endtask

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk) begin : watch_results
    site_indices_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(site_indices_t)-1:0];
      if (expected_sites.size() == 0) begin
        $error("result beat with no expected entry");
        errors++;
      end else begin
        want = expected_sites.pop_front();
        for (int i = 0; i < NumIdx; i++) begin
          if (got.idx[i] !== want.idx[i]) begin
            $error("%s: expected %0d, got %0d", idx_names[i], want.idx[i], got.idx[i]);
            errors++;
          end
        end
        if (got.spatial !== want.spatial) begin
          $error("spatial_index: expected %0d, got %0d", want.spatial, got.spatial);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    site_row_t     rows[$];
    site_row_t     r;
    lattice_geom_t g;

    r = lattice_row(8, 8, 8, 8, 1'b1, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.want.spatial = '0;
    r.want.idx = {24'd518, 24'd2, 24'd1048, 24'd8, 24'd2144, 24'd32, 24'd385, 24'd1, 24'd0};
    rows.push_back(r);
    rows.push_back(lattice_row(8, 8, 8, 8, 1'b1, 7, 7, 7, 7));
    rows.push_back(lattice_row(8, 8, 8, 8, 1'b1, 63, 63, 63, 63));
    rows.push_back(lattice_row(8, 8, 8, 8, 1'b1, 1, 4, 5, 3));
    r = lattice_row(8, 8, 8, 8, 1'b0, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.want.spatial = '0;
    r.want.idx = {24'd515, 24'd1, 24'd1036, 24'd4, 24'd2096, 24'd16, 24'd448, 24'd64, 24'd0};
    rows.push_back(r);
    rows.push_back(lattice_row(8, 8, 8, 8, 1'b0, 5, 3, 6, 2));
    r = lattice_row(0, 0, 0, 0, 1'b1, 63, 63, 63, 63);
    r.typed = 1'b1;
    r.want = '0;
    rows.push_back(r);
    rows.push_back(lattice_row(127, 127, 127, 127, 1'b1, 63, 63, 63, 63));
    rows.push_back(lattice_row(127, 127, 127, 127, 1'b1, 0, 0, 0, 0));
    rows.push_back(lattice_row(64, 64, 64, 64, 1'b0, 63, 0, 63, 0));
    rows.push_back(lattice_row(64, 64, 64, 64, 1'b0, 0, 63, 0, 63));
    rows.push_back(lattice_row(7, 5, 9, 6, 1'b1, 6, 4, 8, 5));
    rows.push_back(lattice_row(7, 5, 9, 6, 1'b1, 0, 0, 0, 0));
    rows.push_back(lattice_row(7, 5, 9, 6, 1'b1, 3, 2, 7, 1));
    rows.push_back(lattice_row(2, 2, 2, 2, 1'b1, 1, 1, 1, 1));
    rows.push_back(lattice_row(1, 63, 1, 2, 1'b1, 0, 62, 0, 1));
    rows.push_back(lattice_row(64, 12, 10, 60, 1'b0, 63, 11, 9, 59));
    rows.push_back(lattice_row(64, 12, 10, 60, 1'b0, 32, 6, 5, 30));
    rows.push_back(lattice_row(65, 100, 1, 3, 1'b1, 10, 63, 0, 2));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].te != t_ext || rows[i].xe != x_ext || rows[i].ye != y_ext ||
          rows[i].ze != z_ext || rows[i].il != il_mode)
        configure_lattice(rows[i].te, rows[i].xe, rows[i].ye, rows[i].ze, rows[i].il);
      send_site(rows[i].ct, rows[i].cx, rows[i].cy, rows[i].cz, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < RandPhases; p++) begin
      calm = (p == RandPhases / 2);
      configure_lattice(rand_extent(), rand_extent(), rand_extent(), rand_extent(),
                        1'($urandom_range(0, 1)));
      g = current_geom();
      for (int k = 0; k < SitesPerPhase; k++)
        send_site(pick_coord(g.te), pick_coord(g.ex), pick_coord(g.ey), pick_coord(g.ez),
                  1'b0, '0);
    end
    calm = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_sites.size() != 0) @(posedge clk);
    repeat (2 * DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS blocked_lattice_site_index");
    end else begin
      $display("FAIL blocked_lattice_site_index");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL blocked_lattice_site_index");
    $finish;
  end

endmodule

FILE: sim.f
hdl/blsi_pkg.sv
hdl/blsi_geom.sv
hdl/blocked_lattice_site_index.sv
hdl/blsi_checker.sv
bench/tb_blocked_lattice_site_index.sv
